### sv/pcsr_pkg.sv
package pcsr_pkg;

  localparam int REQ_W  = 3;
  localparam int PRIO_W = 16;
  localparam int CNT_W  = 11;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_ITEMS_DEF     = 1024;

  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CHANGE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BEGIN  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PLACE  = 3'd4;

  // token that walks the row of cells, one cell per cycle
  typedef struct packed {
    logic                     vld;
    logic [REQ_W-1:0]         req;
    logic signed [PRIO_W-1:0] key;
    logic signed [PRIO_W-1:0] old_key;
    logic [CNT_W-1:0]         sum_less;
    logic [CNT_W-1:0]         sum_all;
    logic                     hit;
    logic                     alloc;
    logic [CNT_W-1:0]         placed;
  } tok_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, cap}) ? cap : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                               input logic [CNT_W-1:0] cap);
    return (v >= cap) ? cap : v + CNT_W'(1);
  endfunction

endpackage

### sv/pcsr_cell.sv
module pcsr_cell #(
  parameter int MAX_ITEMS = pcsr_pkg::MAX_ITEMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pcsr_pkg::tok_t  tok_i,
  output pcsr_pkg::tok_t  tok_o
);
  import pcsr_pkg::*;

  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int CNT_CAP = (MAX_ITEMS < CNT_MAX) ? MAX_ITEMS : CNT_MAX;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CNT_CAP);

  logic                     valid_r, valid_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic [CNT_W-1:0]         mem_r, mem_nxt;
  logic [CNT_W-1:0]         placed_r, placed_nxt;
  tok_t                     tok_r, tok_nxt;

  logic                     key_hit;
  logic                     old_hit;
  logic [CNT_W-1:0]         mem_dec;
  logic [CNT_W-1:0]         base;

  assign key_hit = valid_r && (prio_r == tok_i.key);
  assign old_hit = valid_r && (prio_r == tok_i.old_key);
  assign mem_dec = (old_hit && (mem_r != '0)) ? mem_r - CNT_W'(1) : mem_r;
  assign base    = (tok_i.req == REQ_CHANGE) ? mem_dec : mem_r;

  always_comb begin
    tok_nxt    = tok_i;
    valid_nxt  = valid_r;
    prio_nxt   = prio_r;
    mem_nxt    = mem_r;
    placed_nxt = placed_r;
    if (tok_i.vld) begin
      unique case (tok_i.req)
        REQ_ADD, REQ_CHANGE: begin
          mem_nxt = base;
          if (key_hit) begin
            tok_nxt.hit = 1'b1;
            mem_nxt     = sat_inc(base, CAP);
          end else if (!valid_r && !tok_i.hit && !tok_i.alloc) begin
            // valid entries form a prefix, so the first free cell ends the search
            tok_nxt.alloc = 1'b1;
            valid_nxt     = 1'b1;
            prio_nxt      = tok_i.key;
            mem_nxt       = CNT_W'(1);
            placed_nxt    = '0;
          end
        end
        REQ_REMOVE: begin
          if (key_hit) begin
            tok_nxt.hit = 1'b1;
            mem_nxt     = (mem_r != '0) ? mem_r - CNT_W'(1) : mem_r;
          end
        end
        REQ_BEGIN: begin
          placed_nxt = '0;
        end
        REQ_PLACE: begin
          if (valid_r) begin
            tok_nxt.sum_all = sat_add(tok_i.sum_all, mem_r, CAP);
            if (prio_r < tok_i.key) begin
              tok_nxt.sum_less = sat_add(tok_i.sum_less, mem_r, CAP);
            end
          end
          if (key_hit) begin
            tok_nxt.hit    = 1'b1;
            tok_nxt.placed = placed_r;
            placed_nxt     = sat_inc(placed_r, CAP);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_i.vld) begin
      prio_r   <= prio_nxt;
      mem_r    <= mem_nxt;
      placed_r <= placed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

### sv/priority_counting_sort_ranker_core.sv
// Ranks items by priority with a stable counting sort over a table of distinct priorities,
// one cell per table entry. Each request enters while busy is low, walks the row of cells
// one cell per cycle and yields exactly one result word, registered after the last cell and
// shown for a single cycle with out_valid; the receiver cannot stall, so it must take the
// word in that cycle. busy falls in the cycle that out_valid is high, so the next request
// may be issued then. The rate is set by the walk through the row of cells.
module priority_counting_sort_ranker_core #(
  parameter int TABLE_ENTRIES = pcsr_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_ITEMS     = pcsr_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [pcsr_pkg::REQ_W-1:0]       in_req_type,
  input  logic signed [pcsr_pkg::PRIO_W-1:0] in_priority_req,
  input  logic signed [pcsr_pkg::PRIO_W-1:0] in_old_priority,
  output logic                             out_valid,
  output logic [pcsr_pkg::CNT_W-1:0]       out_slot,
  output logic                             out_found,
  output logic                             out_table_full
);
  import pcsr_pkg::*;

  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int CNT_CAP = (MAX_ITEMS < CNT_MAX) ? MAX_ITEMS : CNT_MAX;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CNT_CAP);

  tok_t             chain [TABLE_ENTRIES+1];
  tok_t             tok0_r, tok0_nxt;
  tok_t             tok_end;
  logic             busy_r, busy_nxt;
  logic             accept;

  logic             out_valid_r;
  logic [CNT_W-1:0] slot_r, slot_nxt;
  logic             found_r, found_nxt;
  logic             full_r, full_nxt;

  assign accept  = start && !busy_r;
  assign tok_end = chain[TABLE_ENTRIES];

  always_comb begin
    tok0_nxt          = '0;
    tok0_nxt.vld      = accept;
    tok0_nxt.req      = in_req_type;
    tok0_nxt.key      = in_priority_req;
    tok0_nxt.old_key  = in_old_priority;
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (tok_end.vld) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= tok_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r <= '0;
    end else begin
      tok0_r <= tok0_nxt;
    end
  end

  assign chain[0] = tok0_r;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pcsr_cell #(
      .MAX_ITEMS(MAX_ITEMS)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .tok_i(chain[i]),
      .tok_o(chain[i+1])
    );
  end

  // result word once the token leaves the last cell
  always_comb begin
    slot_nxt  = '0;
    found_nxt = 1'b0;
    full_nxt  = 1'b0;
    unique case (tok_end.req)
      REQ_ADD, REQ_CHANGE: begin
        found_nxt = tok_end.hit;
        full_nxt  = !tok_end.hit && !tok_end.alloc;
      end
      REQ_REMOVE: begin
        found_nxt = tok_end.hit;
      end
      REQ_PLACE: begin
        found_nxt = tok_end.hit;
        slot_nxt  = tok_end.hit ? sat_add(tok_end.sum_less, tok_end.placed, CAP)
                                : tok_end.sum_all;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok_end.vld) begin
      slot_r  <= slot_nxt;
      found_r <= found_nxt;
      full_r  <= full_nxt;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_slot       = slot_r;
  assign out_found      = found_r;
  assign out_table_full = full_r;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pcsr_pkg::*;

  localparam int TBL         = TABLE_ENTRIES_DEF;
  localparam int CNT_CAP     = (MAX_ITEMS_DEF < 2047) ? MAX_ITEMS_DEF : 2047;
  localparam int POOL_SIZE   = 20;
  localparam int RAND_WORDS  = 490;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [REQ_W-1:0] REQ_IGNORED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_IGNORED_LAST  = 3'd7;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;
  localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7fff;

  typedef struct packed {
    logic [REQ_W-1:0]         req;
    logic signed [PRIO_W-1:0] prio;
    logic signed [PRIO_W-1:0] old_prio;
    logic                     hold_off;
  } req_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] slot;
    logic             found;
    logic             full;
  } rank_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [REQ_W-1:0] in_req_type = '0;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic signed [PRIO_W-1:0] in_old_priority = '0;
  logic out_valid;
  logic [CNT_W-1:0] out_slot;
  logic out_found;
  logic out_table_full;

  priority_counting_sort_ranker_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_priority_req(in_priority_req),
    .in_old_priority(in_old_priority),
    .out_valid      (out_valid),
    .out_slot       (out_slot),
    .out_found      (out_found),
    .out_table_full (out_table_full)
  );

  always #1 clk = ~clk;

  // predicted table contents
  logic                     tbl_valid   [TBL];
  logic signed [PRIO_W-1:0] tbl_prio    [TBL];
  int                       tbl_members [TBL];
  int                       tbl_placed  [TBL];

  req_word_t  request_q [$];
  rank_word_t rank_q [$];
  req_word_t  cur_req;
  logic signed [PRIO_W-1:0] prio_pool [POOL_SIZE];
  bit next_hold = 1'b0;

  int errors = 0;
  int n_total = 0;
  int n_accepted = 0;
  int n_words = 0;
  int n_placed = 0;
  int n_full = 0;
  int n_capped = 0;
  int n_cycles = 0;

  initial begin
    for (int i = 0; i < TBL; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_prio[i] = '0;
      tbl_members[i] = 0;
      tbl_placed[i] = 0;
    end
  end

  function automatic int find_entry(input logic signed [PRIO_W-1:0] p);
    for (int i = 0; i < TBL; i++)
      if (tbl_valid[i] && $signed(tbl_prio[i]) == $signed(p))
        return i;
    return -1;
  endfunction

  function automatic void drop_member(input logic signed [PRIO_W-1:0] p, output logic hit);
    int i;
    i = find_entry(p);
    hit = (i >= 0);
    if (i >= 0 && tbl_members[i] > 0)
      tbl_members[i]--;
  endfunction

  function automatic void add_member(input logic signed [PRIO_W-1:0] p, output logic hit,
                                     output logic full);
    int i;
    i = find_entry(p);
    hit = 1'b0;
    full = 1'b0;
    if (i >= 0) begin
      hit = 1'b1;
      if (tbl_members[i] < CNT_CAP)
        tbl_members[i]++;
      return;
    end
    // new priority takes the lowest free entry, entries are never freed
    for (int j = 0; j < TBL; j++) begin
      if (!tbl_valid[j]) begin
        tbl_valid[j] = 1'b1;
        tbl_prio[j] = p;
        tbl_members[j] = 1;
        tbl_placed[j] = 0;
        return;
      end
    end
    full = 1'b1;
  endfunction

  function automatic rank_word_t rank_request(input req_word_t w);
    rank_word_t r;
    logic scratch;
    int hit;
    int sum;
    r.slot = '0;
    r.found = 1'b0;
    r.full = 1'b0;
    case (w.req)
      REQ_ADD: begin
        add_member(w.prio, r.found, r.full);
      end
      REQ_REMOVE: begin
        drop_member(w.prio, r.found);
      end
      REQ_CHANGE: begin
        drop_member(w.old_prio, scratch);
        add_member(w.prio, r.found, r.full);
      end
      REQ_BEGIN: begin
        for (int i = 0; i < TBL; i++)
          tbl_placed[i] = 0;
      end
      REQ_PLACE: begin
        hit = find_entry(w.prio);
        sum = 0;
        // unknown priority sums every count, known one only the smaller ones
        for (int i = 0; i < TBL; i++) begin
          if (tbl_valid[i] && (hit < 0 || $signed(tbl_prio[i]) < $signed(w.prio))) begin
            sum += tbl_members[i];
            if (sum > CNT_CAP)
              sum = CNT_CAP;
          end
        end
        if (hit >= 0) begin
          r.found = 1'b1;
          sum += tbl_placed[hit];
          if (sum > CNT_CAP)
            sum = CNT_CAP;
          if (tbl_placed[hit] < CNT_CAP)
            tbl_placed[hit]++;
        end
        r.slot = sum[CNT_W-1:0];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic push_req(input logic [REQ_W-1:0] req, input logic signed [PRIO_W-1:0] prio,
                          input logic signed [PRIO_W-1:0] old_prio);
    req_word_t w;
    w.req = req;
    w.prio = prio;
    w.old_prio = old_prio;
    w.hold_off = next_hold;
    next_hold = 1'b0;
    request_q = {request_q, w};
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_prio();
    return prio_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic signed [PRIO_W-1:0] any_prio();
    return PRIO_W'($urandom);
  endfunction

  // driver: one word per handshake, start held until busy is low
  always @(posedge clk) begin : drive
    bit idle;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rank_q = {rank_q, rank_request(cur_req)};
        n_accepted++;
      end
      if (!start || !busy) begin
        idle = (n_accepted < 700 || n_accepted >= 1000) && ($urandom_range(0, 99) < 10);
        if (request_q.size() != 0 && !idle &&
            !(request_q[0].hold_off && rank_q.size() != 0)) begin
          cur_req = request_q.pop_front();
          start <= 1'b1;
          in_req_type <= cur_req.req;
          in_priority_req <= cur_req.prio;
          in_old_priority <= cur_req.old_prio;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word is taken and checked against the oldest prediction
  always @(posedge clk) begin : watch
    rank_word_t want;
    if (rst_n && out_valid) begin
      if (rank_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: slot %0d found %0b full %0b", $time, out_slot,
                 out_found, out_table_full);
      end else begin
        want = rank_q.pop_front();
        n_words++;
        if (want.found && want.slot != 0) n_placed++;
        if (want.full) n_full++;
        if (want.slot == CNT_CAP) n_capped++;
        if (out_slot !== want.slot) begin
          errors++;
          $display("%0t: slot mismatch: expected %0d, got %0d", $time, want.slot, out_slot);
        end
        if (out_found !== want.found) begin
          errors++;
          $display("%0t: found mismatch: expected %0b, got %0b", $time, want.found, out_found);
        end
        if (out_table_full !== want.full) begin
          errors++;
          $display("%0t: table_full mismatch: expected %0b, got %0b", $time, want.full,
                   out_table_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", n_cycles, rank_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : main
    int r;
    int k;
    int n_rand;
    int hold_mark;

    prio_pool[0] = PRIO_MIN;
    prio_pool[1] = PRIO_MAX;
    prio_pool[2] = '0;
    prio_pool[3] = -16'sd1;
    for (int i = 4; i < POOL_SIZE; i++)
      prio_pool[i] = any_prio();

    // directed opening: empty table, extremes, zero counts, ignored codes
    push_req(REQ_PLACE, 16'sd5, any_prio());
    push_req(REQ_REMOVE, 16'sd5, any_prio());
    push_req(REQ_ADD, PRIO_MIN, any_prio());
    push_req(REQ_ADD, PRIO_MAX, any_prio());
    push_req(REQ_ADD, 16'sd0, any_prio());
    push_req(REQ_ADD, PRIO_MIN, any_prio());
    push_req(REQ_REMOVE, 16'sd0, any_prio());
    push_req(REQ_REMOVE, 16'sd0, any_prio());
    push_req(REQ_CHANGE, -16'sd1, PRIO_MIN);
    push_req(REQ_CHANGE, PRIO_MAX, 16'sd1234);
    push_req(REQ_BEGIN, any_prio(), any_prio());
    push_req(REQ_PLACE, PRIO_MIN, any_prio());
    push_req(REQ_PLACE, PRIO_MAX, any_prio());
    push_req(REQ_PLACE, PRIO_MAX, any_prio());
    push_req(REQ_PLACE, PRIO_MAX, any_prio());
    push_req(REQ_PLACE, 16'sd0, any_prio());
    push_req(REQ_PLACE, -16'sd1, any_prio());
    push_req(REQ_PLACE, 16'sd77, any_prio());
    for (int c = REQ_IGNORED_FIRST; c <= REQ_IGNORED_LAST; c++)
      push_req(REQ_W'(c), any_prio(), any_prio());

    // random part: mostly placement passes and table upkeep over a small pool
    n_rand = 0;
    hold_mark = 400;
    while (n_rand < RAND_WORDS) begin
      if (n_rand >= hold_mark) begin
        next_hold = 1'b1;
        hold_mark += 800;
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        push_req(REQ_ADD, pick_prio(), any_prio());
        n_rand++;
      end else if (r < 40) begin
        push_req(REQ_REMOVE, pick_prio(), any_prio());
        n_rand++;
      end else if (r < 50) begin
        push_req(REQ_CHANGE, pick_prio(), pick_prio());
        n_rand++;
      end else if (r < 75) begin
        k = $urandom_range(1, 12);
        push_req(REQ_BEGIN, any_prio(), any_prio());
        repeat (k) push_req(REQ_PLACE, pick_prio(), any_prio());
        n_rand += k + 1;
      end else if (r < 85) begin
        push_req(REQ_PLACE, pick_prio(), any_prio());
        n_rand++;
      end else if (r < 95) begin
        push_req(REQ_W'($urandom_range(REQ_ADD, REQ_PLACE)), any_prio(), any_prio());
        n_rand++;
      end else begin
        push_req(REQ_W'($urandom_range(REQ_IGNORED_FIRST, REQ_IGNORED_LAST)), any_prio(),
                 any_prio());
        n_rand++;
      end
    end

    // drive one count into saturation, then look at it from every side
    next_hold = 1'b1;
    repeat (CNT_CAP + 6) push_req(REQ_ADD, PRIO_MAX, any_prio());
    push_req(REQ_PLACE, PRIO_MAX, any_prio());
    push_req(REQ_PLACE, any_prio(), any_prio());
    push_req(REQ_REMOVE, PRIO_MAX, any_prio());
    push_req(REQ_BEGIN, any_prio(), any_prio());
    push_req(REQ_PLACE, PRIO_MAX, any_prio());
    push_req(REQ_PLACE, PRIO_MIN, any_prio());
    push_req(REQ_PLACE, pick_prio(), any_prio());
    push_req(REQ_CHANGE, PRIO_MIN, PRIO_MAX);
    push_req(REQ_PLACE, PRIO_MAX, any_prio());
    n_total = request_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_total || rank_q.size() != 0)
      @(posedge clk);
    repeat (2 * (TBL + 2)) @(posedge clk);

    $display("checked %0d result words from %0d requests in %0d cycles", n_words, n_total,
             n_cycles);
    $display("  %0d placements in the table, %0d table-full flags, %0d slots at the cap",
             n_placed, n_full, n_capped);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
